FILE: hdl/tts_pkg.sv
// Shared types, marker constants and marker lookup for the think-tag splitter.
package tts_pkg;

    localparam logic       CMD_DATA  = 1'b0;
    localparam logic       CMD_FLUSH = 1'b1;

    localparam logic [7:0] CHAR_LT   = 8'h3C;  // '<'
    localparam logic [3:0] OPEN_LEN  = 4'd7;   // "<think>"
    localparam logic [3:0] CLOSE_LEN = 4'd8;   // "</think>"

    // One release job: held marker prefix, optionally followed by the current byte.
    typedef struct packed {
        logic       valid;
        logic [2:0] last_idx;
        logic [2:0] held;
        logic       has_byte;
        logic       think;
        logic [7:0] data;
    } t_job;

    // Character at a position of the marker that is expected in the given stream.
    function automatic logic [7:0] mark_char(input logic think, input logic [2:0] pos);
        logic [7:0] ch;
        ch = 8'h00;
        if (think) begin
            unique case (pos)
                3'd0: ch = 8'h3C;  // '<'
                3'd1: ch = 8'h2F;  // '/'
                3'd2: ch = 8'h74;  // 't'
                3'd3: ch = 8'h68;  // 'h'
                3'd4: ch = 8'h69;  // 'i'
                3'd5: ch = 8'h6E;  // 'n'
                3'd6: ch = 8'h6B;  // 'k'
                3'd7: ch = 8'h3E;  // '>'
                default: ch = 8'h00;
            endcase
        end else begin
            unique case (pos)
                3'd0: ch = 8'h3C;  // '<'
                3'd1: ch = 8'h74;  // 't'
                3'd2: ch = 8'h68;  // 'h'
                3'd3: ch = 8'h69;  // 'i'
                3'd4: ch = 8'h6E;  // 'n'
                3'd5: ch = 8'h6B;  // 'k'
                3'd6: ch = 8'h3E;  // '>'
                3'd7: ch = 8'h00;
                default: ch = 8'h00;
            endcase
        end
        return ch;
    endfunction

endpackage

FILE: hdl/tts_ctrl.sv
// Marker matcher: stream and held-count state, and release job for each request.
module tts_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic          i_command,
    input  logic [7:0]    i_data_byte,
    output tts_pkg::t_job o_job
);

    logic       r_think;
    logic [2:0] r_count;
    logic       n_think;
    logic [2:0] n_count;
    logic [3:0] mark_len;
    logic [3:0] count_inc;
    logic [3:0] job_sum;

    always_comb begin
        mark_len  = r_think ? tts_pkg::CLOSE_LEN : tts_pkg::OPEN_LEN;
        count_inc = {1'b0, r_count} + 4'd1;
        n_think   = r_think;
        n_count   = r_count;

        o_job.valid    = 1'b0;
        o_job.held     = r_count;
        o_job.has_byte = 1'b0;
        o_job.think    = r_think;
        o_job.data     = i_data_byte;

        if (i_command == tts_pkg::CMD_FLUSH) begin
            o_job.valid = (r_count != 3'd0);
            n_count     = 3'd0;
        end else if (i_data_byte == tts_pkg::mark_char(r_think, r_count)) begin
            // extend the match; a full marker toggles the stream and emits nothing
            if (count_inc == mark_len) begin
                n_think = ~r_think;
                n_count = 3'd0;
            end else begin
                n_count = count_inc[2:0];
            end
        end else begin
            // mismatch: release held prefix, then the byte unless it opens a new match
            o_job.has_byte = (i_data_byte != tts_pkg::CHAR_LT);
            n_count        = o_job.has_byte ? 3'd0 : 3'd1;
            o_job.valid    = (r_count != 3'd0) || o_job.has_byte;
        end

        job_sum        = {1'b0, r_count} + {3'b000, o_job.has_byte} - 4'd1;
        o_job.last_idx = job_sum[2:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_think <= 1'b0;
            r_count <= 3'd0;
        end else if (i_accept) begin
            r_think <= n_think;
            r_count <= n_count;
        end
    end

endmodule

FILE: hdl/tts_emit.sv
// Result register: plays out one release job, one byte per beat.
module tts_emit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_load,
    input  tts_pkg::t_job i_job,
    output logic          o_ready,
    output logic          o_valid,
    input  logic          i_out_ready,
    output logic [7:0]    o_byte,
    output logic          o_think,
    output logic          o_last
);

    logic          r_valid;
    logic [2:0]    r_idx;
    tts_pkg::t_job r_job;
    logic          beat_last;

    assign beat_last = (r_idx == r_job.last_idx);
    assign o_ready   = !r_valid || (i_out_ready && beat_last);
    assign o_valid   = r_valid;
    assign o_last    = beat_last;
    assign o_think   = r_job.think;
    assign o_byte    = (r_idx < r_job.held) ? tts_pkg::mark_char(r_job.think, r_idx)
                                            : r_job.data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 3'd0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_idx   <= 3'd0;
        end else if (r_valid && i_out_ready) begin
            if (beat_last) begin
                r_valid <= 1'b0;
            end else begin
                r_idx <= r_idx + 3'd1;
            end
        end
    end

    // payload needs no reset
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_job <= i_job;
        end
    end

endmodule

FILE: hdl/think_tag_stream_splitter.sv
// Top level of the think-tag stream splitter.
//
// Slave channel s_axis_*: one request per byte. s_axis_tuser is the command
// (0 = text byte in s_axis_tdata, 1 = flush held bytes; tdata ignored).
// Master channel m_axis_*: one beat per released byte, m_axis_tuser set for
// the thinking stream, m_axis_tlast on the final beat caused by a request.
// "<think>" and "</think>" switch streams and never appear on the output;
// bytes that may still grow into a marker are held and released later.
//
// The first beat of a request shows in the cycle after acceptance. Plain
// text flows at one byte per cycle while m_axis_tready stays high; a
// request that releases N bytes (held prefix plus current byte, N up to 8)
// holds the slave side until its last beat is taken, since the single
// result register plays out one byte a beat.
// Reset clears the stream to reply and drops any held prefix and pending
// beats. When the receiver stalls, the current beat holds and s_axis_tready
// drops until the last beat of the pending request is taken.
module think_tag_stream_splitter (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  logic       s_axis_tuser,   // [0] command
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic       m_axis_tuser,   // [0] to_thinking
    output logic       m_axis_tlast
);

    logic          in_accept;
    tts_pkg::t_job job;

    assign in_accept = s_axis_tvalid && s_axis_tready;

    tts_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_command   (s_axis_tuser),
        .i_data_byte (s_axis_tdata),
        .o_job       (job)
    );

    tts_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (in_accept && job.valid),
        .i_job       (job),
        .o_ready     (s_axis_tready),
        .o_valid     (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_byte      (m_axis_tdata),
        .o_think     (m_axis_tuser),
        .o_last      (m_axis_tlast)
    );

    // slave side only stalls behind a pending result
    a_stall_needs_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("s_axis_tready low with no pending beat");

    // mid-job beats block new requests
    a_midjob_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tlast) |-> !s_axis_tready)
        else $error("request accepted before job finished");

    // last beat taken with no new request leaves the output empty
    a_job_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast && !(s_axis_tvalid && s_axis_tready))
        |=> !m_axis_tvalid)
        else $error("beat shown after job completed");

endmodule
